// ===== rtl/core/efs_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the epicycle
// synthesis block. No dependencies.
`timescale 1ns / 1ps

package efs_pkg;

  localparam int MAX_TERMS    = 64;
  localparam int ANGLE_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_TERMS);
  localparam int CNT_W        = $clog2(MAX_TERMS + 1);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CFG_W        = 21;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X   = 2'd0,
    CFG_ORIGIN_Y   = 2'd1,
    CFG_ROTATION   = 2'd2,
    CFG_TERM_COUNT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  term_index;
    logic [9:0]  harmonic;
    logic [19:0] amplitude;
    logic [15:0] term_phase;
    logic [15:0] time_angle;
  } efs_in_t;

  typedef struct packed {
    logic signed [27:0] tip_x;
    logic signed [27:0] tip_y;
  } efs_out_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic [1:0]         quad;
    logic [19:0]        amp;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cordic_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [27:0] dx;
    logic signed [27:0] dy;
  } term_t;

  function automatic logic signed [32:0] atan_turns(input logic [STEP_W-1:0] i);
    logic signed [32:0] r;
    case (i)
      4'd0:    r = 33'sd536870912;
      4'd1:    r = 33'sd316933406;
      4'd2:    r = 33'sd167458907;
      4'd3:    r = 33'sd85004756;
      4'd4:    r = 33'sd42667331;
      4'd5:    r = 33'sd21354465;
      4'd6:    r = 33'sd10679838;
      4'd7:    r = 33'sd5340245;
      4'd8:    r = 33'sd2670163;
      4'd9:    r = 33'sd1335087;
      4'd10:   r = 33'sd667544;
      4'd11:   r = 33'sd333772;
      4'd12:   r = 33'sd166886;
      4'd13:   r = 33'sd83443;
      4'd14:   r = 33'sd41722;
      default: r = 33'sd20861;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/efs_cordic_cell.sv =====
// One CORDIC rotation cell of the chain; registers its result every cycle.
// Depends on efs_pkg.
`timescale 1ns / 1ps

module efs_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [efs_pkg::STEP_W-1:0]  step_i,
  input  efs_pkg::cordic_t            d_i,
  output efs_pkg::cordic_t            q_o
);
  import efs_pkg::*;

  cordic_t            q_d, q_q;
  logic signed [32:0] dx, dy, at;

  always_comb begin
    dx  = d_i.y >>> step_i;
    dy  = d_i.x >>> step_i;
    at  = atan_turns(step_i);
    q_d = d_i;
    if (!d_i.z[32]) begin
      q_d.x = d_i.x - dx;
      q_d.y = d_i.y + dy;
      q_d.z = d_i.z - at;
    end else begin
      q_d.x = d_i.x + dx;
      q_d.y = d_i.y - dy;
      q_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== rtl/core/efs_scale.sv =====
// Turns the chain output into Q1.15 cos and sin, scales by the radius and
// rounds each product to Q.8, over three registered stages. Depends on efs_pkg.
`timescale 1ns / 1ps

module efs_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  efs_pkg::cordic_t d_i,
  output efs_pkg::term_t   q_o
);
  import efs_pkg::*;

  logic signed [17:0] rx, ry;
  logic signed [15:0] cq, sq, c_d, s_d;
  logic signed [15:0] c_q, s_q;
  logic [19:0]        amp_q;
  logic signed [36:0] px_d, py_d, px_q, py_q;
  logic signed [36:0] rnd_x, rnd_y;
  logic [1:0]         vld_q, last_q;
  term_t              t_q;

  function automatic logic signed [15:0] clamp15(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sd32767;
    else if (v < -18'sd32767) r = -16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  always_comb begin
    rx = 18'((d_i.x + 33'sd16384) >>> 15);
    ry = 18'((d_i.y + 33'sd16384) >>> 15);
    cq = clamp15(rx);
    sq = clamp15(ry);
    case (d_i.quad)
      2'd0: begin c_d = cq;  s_d = sq;  end
      2'd1: begin c_d = -sq; s_d = cq;  end
      2'd2: begin c_d = -cq; s_d = -sq; end
      default: begin c_d = sq; s_d = -cq; end
    endcase
    px_d  = 37'(signed'({1'b0, amp_q}) * c_q);
    py_d  = 37'(signed'({1'b0, amp_q}) * s_q);
    rnd_x = (px_q + 37'sd16384) >>> 15;
    rnd_y = (py_q + 37'sd16384) >>> 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      last_q     <= '0;
      t_q        <= '0;
    end else begin
      vld_q      <= {vld_q[0], d_i.vld};
      last_q     <= {last_q[0], d_i.last};
      t_q.vld    <= vld_q[1];
      t_q.last   <= last_q[1];
      t_q.dx     <= rnd_x[27:0];
      t_q.dy     <= rnd_y[27:0];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    s_q    <= s_d;
    amp_q  <= d_i.amp;
    px_q   <= px_d;
    py_q   <= py_d;
  end

  assign q_o = t_q;

endmodule

// ===== rtl/core/epicycle_fourier_synthesis.sv =====
// Top level of the epicycle synthesis block: term table, sequencer, angle
// stage, CORDIC cell chain, scaling and accumulator. Depends on efs_pkg,
// efs_cordic_cell and efs_scale.
//
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_stall  | efs_in_t: cmd, slot, term, time
//  out     | output    | out_valid/out_stall| efs_out_t: tip_x, tip_y
//  cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// A load beat is taken whenever the block is not busy. An evaluate beat stalls
// the input while term_count terms are issued and pass through the read,
// angle, CORDIC chain of 16 cells, scaling stages and accumulator, and until
// the result has moved into the output register.
// The term table has one write port and one registered read port.
// Reset clears control and configuration; the table is not cleared.
// A result waits in the output register while loads are still taken.
`timescale 1ns / 1ps

module epicycle_fourier_synthesis (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  efs_pkg::efs_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output efs_pkg::efs_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [efs_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import efs_pkg::*;

  localparam int WORD_W = 46;

  logic [WORD_W-1:0]   mem_q [MAX_TERMS];
  logic [WORD_W-1:0]   rd_q;
  logic                a_vld_q, a_last_q;

  logic signed [20:0]  org_x_q, org_y_q;
  logic [15:0]         rot_q;
  logic [6:0]          tcount_q;

  logic                busy_q, issuing_q, pending_q, out_valid_q;
  logic [CNT_W-1:0]    cnt_q, n_q, n_d;
  logic [15:0]         t_q;
  logic signed [27:0]  acc_x_q, acc_y_q;
  efs_out_t            out_q;

  logic                accept, issue_last, xfer;
  logic [26:0]         ang_sum;
  logic [ANGLE_BITS-1:0] ang_q;
  logic [19:0]         b_amp_q;
  logic                b_vld_q, b_last_q;
  logic [31:0]         ang32, ang_rnd, res;
  cordic_t             c_d;
  cordic_t             chain [CORDIC_STEPS+1];
  term_t               term;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign issue_last = (cnt_q == n_q - CNT_W'(1));
  assign xfer       = pending_q && (!out_valid_q || !out_stall_i);
  assign n_d        = (tcount_q > 7'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(tcount_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      rot_q    <= '0;
      tcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:   org_x_q  <= cfg_wdata_i;
        CFG_ORIGIN_Y:   org_y_q  <= cfg_wdata_i;
        CFG_ROTATION:   rot_q    <= cfg_wdata_i[15:0];
        CFG_TERM_COUNT: tcount_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Term table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && !in_data_i.cmd) begin
      mem_q[in_data_i.term_index[IDX_W-1:0]] <=
        {in_data_i.harmonic, in_data_i.amplitude, in_data_i.term_phase};
    end
    rd_q <= mem_q[cnt_q[IDX_W-1:0]];
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issuing_q   <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      a_vld_q     <= 1'b0;
      a_last_q    <= 1'b0;
    end else begin
      a_vld_q  <= issuing_q;
      a_last_q <= issuing_q && issue_last;
      if (accept && in_data_i.cmd) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= n_d;
        if (n_d == '0) pending_q <= 1'b1;
        else issuing_q <= 1'b1;
      end
      if (issuing_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (issue_last) issuing_q <= 1'b0;
      end
      if (term.vld && term.last) pending_q <= 1'b1;
      if (xfer) begin
        out_valid_q <= 1'b1;
        pending_q   <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.cmd) begin
      t_q     <= in_data_i.time_angle;
      acc_x_q <= 28'(org_x_q);
      acc_y_q <= 28'(org_y_q);
    end else if (term.vld) begin
      acc_x_q <= acc_x_q + term.dx;
      acc_y_q <= acc_y_q + term.dy;
    end
    if (xfer) begin
      out_q.tip_x <= acc_x_q;
      out_q.tip_y <= acc_y_q;
    end
  end

  // Angle stage: harmonic * time + phase + rotation, modulo one turn.
  assign ang_sum = 27'(rd_q[45:36] * t_q) + 27'(rd_q[15:0]) + 27'(rot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      b_last_q <= 1'b0;
    end else begin
      b_vld_q  <= a_vld_q;
      b_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q   <= ang_sum[ANGLE_BITS-1:0];
    b_amp_q <= rd_q[35:16];
  end

  // Split into the nearest quarter turn and a residual within one eighth.
  always_comb begin
    ang32   = {ang_q, {(32-ANGLE_BITS){1'b0}}};
    ang_rnd = ang32 + 32'h2000_0000;
    res     = ang32 - {ang_rnd[31:30], 30'd0};
    c_d.vld  = b_vld_q;
    c_d.last = b_last_q;
    c_d.quad = ang_rnd[31:30];
    c_d.amp  = b_amp_q;
    c_d.x    = 33'sd652032874;
    c_d.y    = '0;
    c_d.z    = signed'({res[31], res});
  end

  assign chain[0] = c_d;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
    efs_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (STEP_W'(gi)),
      .d_i    (chain[gi]),
      .q_o    (chain[gi+1])
    );
  end

  efs_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (chain[CORDIC_STEPS]),
    .q_o    (term)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_pending_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> busy_q) else $error("result pending while not busy");
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> busy_q) else $error("issuing terms while not busy");
  a_no_stray_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !term.vld) else $error("term arrived outside an evaluation");
  a_xfer_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> !busy_q && out_valid_o) else $error("transfer did not free block");
`endif

endmodule
